// ===== hdl/pal_pkg.sv =====
// shared types, codes and field widths for the positional array list
`timescale 1ns / 1ps
package pal_pkg;

  // fixed field widths
  localparam int unsigned CMD_BITS      = 2;
  localparam int unsigned POS_BITS      = 9;
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned STAT_BITS     = 2;
  localparam int unsigned OUT_WORD_BITS = 32;
  localparam int unsigned COUNT_BITS    = 9;

  // parameter defaults
  localparam int unsigned DEF_CAPACITY  = 256;
  localparam int unsigned DEF_WORD_BITS = 32;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WAIT = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  // broadcast control to every cell
  typedef struct packed {
    logic                ins;
    logic                del;
    logic [POS_BITS-1:0] pos_m1;
  } ctrl_t;

endpackage

// ===== hdl/positional_array_list.sv =====
// top level: positional list built from a row of shifting cells
//
//  channel   dir  tdata (low bit up)                     tuser
//  s_axis    in   position[8:0], value[40:9]             command[1:0]
//  m_axis    out  word[31:0], count[40:32], empty[41]    status[1:0]
//
// one request at a time; insert and delete shift the cells from the position upward
// in the accept cycle; the read word climbs a registered or-tree of clog2(CAPACITY)
// levels into a result register before tvalid rises
// a new request is taken the cycle after the previous result has been taken
// reset clears the fill count and control; cell contents are undefined until written
`timescale 1ns / 1ps
module positional_array_list
  import pal_pkg::*;
#(
  parameter int unsigned CAPACITY  = DEF_CAPACITY,
  parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // position[8:0], value[40:9], zero pad
  input  logic [1:0]  s_axis_tuser_i,   // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // word[31:0], count[40:32], empty[41], zero pad
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  localparam int unsigned FW       = $clog2(CAPACITY + 1);
  localparam int unsigned CW       = ((FW > POS_BITS) ? FW : POS_BITS) + 1;
  localparam int unsigned TREE_LVL = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(TREE_LVL + 2);

  state_e                state_q, state_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  status_e               stat_q, stat_d;
  logic [COUNT_BITS-1:0] count_q;
  logic                  empty_q;
  logic                  want_word_q, want_word_d;
  logic [OUT_WORD_BITS-1:0] word_q;

  logic                  accept;
  cmd_e                  cmd;
  logic [POS_BITS-1:0]   pos;
  logic [VALUE_BITS-1:0] value;
  logic [CW-1:0]         pos_x, fill_x;
  ctrl_t                 ctrl;
  logic [WORD_BITS-1:0]  store_val;
  logic [WORD_BITS-1:0]  root;

  logic [CAPACITY-1:0][WORD_BITS-1:0] cell_data;
  logic [CAPACITY-1:0][WORD_BITS-1:0] cell_tap;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd             = cmd_e'(s_axis_tuser_i);
  assign pos             = s_axis_tdata_i[8:0];
  assign value           = s_axis_tdata_i[40:9];
  assign pos_x           = CW'(pos);
  assign fill_x          = CW'(fill_q);
  assign store_val       = WORD_BITS'(signed'(value));

  // request decode and range checks
  always_comb begin
    stat_d      = STAT_OK;
    fill_d      = fill_q;
    want_word_d = 1'b0;
    ctrl.ins    = 1'b0;
    ctrl.del    = 1'b0;
    ctrl.pos_m1 = pos - POS_BITS'(1);
    case (cmd)
      CMD_INSERT: begin
        if ((pos_x == '0) || (pos_x > fill_x + CW'(1))) begin
          stat_d = STAT_RANGE;
        end else if (fill_x == CW'(CAPACITY)) begin
          stat_d = STAT_FULL;
        end else begin
          ctrl.ins = accept;
          fill_d   = fill_q + FW'(1);
        end
      end
      CMD_DELETE: begin
        if ((pos_x == '0) || (pos_x > fill_x)) begin
          stat_d = STAT_RANGE;
        end else begin
          ctrl.del    = accept;
          fill_d      = fill_q - FW'(1);
          want_word_d = 1'b1;
        end
      end
      CMD_READ: begin
        if ((pos_x == '0) || (pos_x > fill_x)) begin
          stat_d = STAT_RANGE;
        end else begin
          want_word_d = 1'b1;
        end
      end
      default: begin
        stat_d = STAT_RANGE;
      end
    endcase
  end

  // row of cells, each fed by both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[i+1];
    end
    pal_cell #(
      .WORD_BITS(WORD_BITS),
      .IDX      (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .value_i(store_val),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[i]),
      .tap_o  (cell_tap[i])
    );
  end

  pal_read_tree #(
    .WORD_BITS(WORD_BITS),
    .CAPACITY (CAPACITY)
  ) u_tree (
    .clk_i (clk_i),
    .load_i(accept),
    .leaf_i(cell_tap),
    .root_o(root)
  );

  // sequencer: accept, wait for the tree, hold the result
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_WAIT;
          cnt_d   = CNT_W'(TREE_LVL);
        end
      end
      ST_WAIT: begin
        if (cnt_q == '0) begin
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stat_q      <= stat_d;
      count_q     <= COUNT_BITS'(fill_d);
      empty_q     <= (fill_d == '0);
      want_word_q <= want_word_d;
    end
    if ((state_q == ST_WAIT) && (cnt_q == '0)) begin
      word_q <= want_word_q ? OUT_WORD_BITS'(signed'(root)) : '0;
    end
  end

  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tuser_o  = stat_q;
  assign m_axis_tdata_o  = {6'd0, empty_q, count_q, word_q};

  // checks
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("request taken while a result is pending");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready right after accept");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_error_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (stat_q != STAT_OK)) |-> (word_q == '0))
    else $error("nonzero word on error result");

endmodule

// ===== hdl/pal_cell.sv =====
// one list entry: holds a word and shifts it toward either neighbor
`timescale 1ns / 1ps
module pal_cell
  import pal_pkg::*;
#(
  parameter int unsigned WORD_BITS = DEF_WORD_BITS,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  ctrl_t                ctrl_i,
  input  logic [WORD_BITS-1:0] value_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] data_o,
  output logic [WORD_BITS-1:0] tap_o
);

  localparam logic [31:0] MY_IDX = 32'(IDX);

  logic [WORD_BITS-1:0] data_q, data_d;
  logic [31:0]          pos32;
  logic                 at_pos, above_pos;

  assign pos32     = 32'(ctrl_i.pos_m1);
  assign at_pos    = (pos32 == MY_IDX);
  assign above_pos = (MY_IDX > pos32);

  // insert opens a gap at the position, delete closes it
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins && at_pos) begin
      data_d = value_i;
    end else if (ctrl_i.ins && above_pos) begin
      data_d = left_i;
    end else if (ctrl_i.del && (at_pos || above_pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // only the addressed cell drives its word into the read tree
  assign tap_o  = at_pos ? data_q : '0;

endmodule

// ===== hdl/pal_read_tree.sv =====
// registered or-tree that collects the one selected cell word
`timescale 1ns / 1ps
module pal_read_tree
  import pal_pkg::*;
#(
  parameter int unsigned WORD_BITS = DEF_WORD_BITS,
  parameter int unsigned CAPACITY  = DEF_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic [CAPACITY-1:0][WORD_BITS-1:0]  leaf_i,
  output logic [WORD_BITS-1:0]                root_o
);

  localparam int unsigned LVL = $clog2(CAPACITY);
  localparam int unsigned N   = 1 << LVL;

  // heap layout: node 1 is the root, leaves at N to 2N-1
  logic [WORD_BITS-1:0] node_q [1:2*N-1];

  for (genvar k = 0; k < N; k++) begin : g_leaf
    if (k < CAPACITY) begin : g_used
      always_ff @(posedge clk_i) begin
        if (load_i) begin
          node_q[N+k] <= leaf_i[k];
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        node_q[N+k] <= '0;
      end
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_node
    always_ff @(posedge clk_i) begin
      node_q[k] <= node_q[2*k] | node_q[2*k+1];
    end
  end

  assign root_o = node_q[1];

endmodule

// ===== tb/positional_array_list_tb.sv =====
// self-checking testbench for the positional array list: stream driver, monitor and list predictor
`timescale 1ns / 1ps
module positional_array_list_tb;
  import pal_pkg::*;

  localparam int unsigned CAP          = DEF_CAPACITY;
  localparam int unsigned WB           = DEF_WORD_BITS;
  localparam int unsigned LATENCY      = $clog2(DEF_CAPACITY) + 2;
  localparam int unsigned RANDOM_ITEMS = 1430;
  localparam int unsigned CALM_TAIL    = 120;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned POS_MAX      = (1 << POS_BITS) - 1;

  // the command code that the block leaves unused
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_BITS-1:0]   cmd;
    logic [POS_BITS-1:0]   pos;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct {
    logic [STAT_BITS-1:0]     status;
    logic [OUT_WORD_BITS-1:0] word;
    logic [COUNT_BITS-1:0]    count;
    logic                     empty;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  positional_array_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  req_t        request_q[$];
  outcome_t    outcome_q[$];
  int unsigned err_cnt;
  int unsigned req_count;
  int unsigned cycle_cnt;
  int unsigned plan_len;
  bit          req_fire;
  bit          idle_on;

  // predicted list contents and length
  logic [WB-1:0] list_mem [CAP];
  int unsigned   list_len;
  int unsigned   peak_len;
  int unsigned   n_ok, n_range, n_full;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sign-extend a stored word to the reported width
  function automatic logic [OUT_WORD_BITS-1:0] widen_word(logic [WB-1:0] w);
    logic signed [63:0] s;
    s = $signed(w);
    return s[OUT_WORD_BITS-1:0];
  endfunction

  // apply one request to the predicted list and return its result
  function automatic outcome_t apply_request(req_t r);
    outcome_t    o;
    int unsigned p;
    int unsigned i;
    o.status = STAT_OK;
    o.word   = '0;
    p        = r.pos;
    case (r.cmd)
      CMD_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          o.status = STAT_RANGE;
        end else if (list_len >= CAP) begin
          o.status = STAT_FULL;
        end else begin
          for (i = list_len; i > p - 1; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = r.value[WB-1:0];
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > list_len) begin
          o.status = STAT_RANGE;
        end else begin
          o.word = widen_word(list_mem[p-1]);
          for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      CMD_READ: begin
        if (p < 1 || p > list_len) o.status = STAT_RANGE;
        else o.word = widen_word(list_mem[p-1]);
      end
      default: begin
        o.status = STAT_RANGE;
      end
    endcase
    o.count = list_len[COUNT_BITS-1:0];
    o.empty = (list_len == 0);
    return o;
  endfunction

  // queue one request and track the list length it leads to
  task automatic add_request(logic [CMD_BITS-1:0] cmd, int unsigned pos,
                             logic [VALUE_BITS-1:0] value);
    req_t r;
    r.cmd   = cmd;
    r.pos   = pos[POS_BITS-1:0];
    r.value = value;
    request_q.push_back(r);
    if (cmd == CMD_INSERT && pos >= 1 && pos <= plan_len + 1 && plan_len < CAP) plan_len++;
    else if (cmd == CMD_DELETE && pos >= 1 && pos <= plan_len) plan_len--;
  endtask

  // accept requests, predict, and check results at the rising edge
  always @(posedge clk_i) begin
    outcome_t exp_o;
    outcome_t got_o;
    req_t     r;
    req_fire = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_o.status = m_axis_tuser;
        got_o.word   = m_axis_tdata[31:0];
        got_o.count  = m_axis_tdata[40:32];
        got_o.empty  = m_axis_tdata[41];
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding: status %0d word %0h",
                 got_o.status, got_o.word);
          err_cnt++;
        end else begin
          exp_o = outcome_q.pop_front();
          if (got_o.status !== exp_o.status) begin
            $error("status: expected %0d, got %0d", exp_o.status, got_o.status);
            err_cnt++;
          end
          if (got_o.word !== exp_o.word) begin
            $error("word: expected %0h, got %0h", exp_o.word, got_o.word);
            err_cnt++;
          end
          if (got_o.count !== exp_o.count) begin
            $error("count: expected %0d, got %0d", exp_o.count, got_o.count);
            err_cnt++;
          end
          if (got_o.empty !== exp_o.empty) begin
            $error("empty: expected %0b, got %0b", exp_o.empty, got_o.empty);
            err_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        r.cmd   = s_axis_tuser;
        r.pos   = s_axis_tdata[8:0];
        r.value = s_axis_tdata[40:9];
        exp_o   = apply_request(r);
        outcome_q.push_back(exp_o);
        if (exp_o.status == STAT_OK) n_ok++;
        else if (exp_o.status == STAT_FULL) n_full++;
        else n_range++;
        if (list_len > peak_len) peak_len = list_len;
        req_count++;
        req_fire = 1'b1;
      end
    end
    idle_on = (request_q.size() > CALM_TAIL) && (((req_count / 128) % 4) != 3);
  end

  // request driver
  int unsigned send_gap;
  always @(negedge clk_i) begin
    req_t nxt;
    if (rst_ni && (!s_axis_tvalid || req_fire)) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (request_q.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 8);
        s_axis_tvalid <= 1'b0;
      end else if (request_q.size() != 0) begin
        nxt = request_q.pop_front();
        s_axis_tdata  <= {7'd0, nxt.value, nxt.pos};
        s_axis_tuser  <= nxt.cmd;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: short random stalls and one long hold
  int unsigned stall_left;
  bit          hold_done;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && req_count >= HOLD_AT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned n;
    int unsigned pick;
    int unsigned sel;
    int unsigned lim;
    int unsigned pos;
    int unsigned at_full;
    bit          grow;
    logic [CMD_BITS-1:0]   cmd;
    logic [VALUE_BITS-1:0] value;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    err_cnt   = 0;
    req_count = 0;
    plan_len  = 0;
    list_len  = 0;
    peak_len  = 0;
    n_ok      = 0;
    n_range   = 0;
    n_full    = 0;
    send_gap  = 0;
    stall_left = 0;
    hold_done = 1'b0;
    req_fire  = 1'b0;
    idle_on   = 1'b0;

    // directed: empty list, range edges, word extremes, shifts at both ends
    add_request(CMD_READ,   1, 32'h0);
    add_request(CMD_DELETE, 1, 32'h0);
    add_request(CMD_INSERT, 0, 32'h1234_5678);
    add_request(CMD_INSERT, 2, 32'h1234_5678);
    add_request(CMD_INSERT, 1, 32'h8000_0000);
    add_request(CMD_INSERT, 2, 32'h7FFF_FFFF);
    add_request(CMD_INSERT, 1, 32'hFFFF_FFFF);
    add_request(CMD_INSERT, 2, 32'h0000_0000);
    add_request(CMD_INSERT, 6, 32'h5555_AAAA);
    add_request(CMD_READ,   1, 32'hFFFF_FFFF);
    add_request(CMD_READ,   2, 32'h0);
    add_request(CMD_READ,   3, 32'h0);
    add_request(CMD_READ,   4, 32'h0);
    add_request(CMD_READ,   5, 32'h0);
    add_request(CMD_READ,   0, 32'h0);
    add_request(CMD_READ,   POS_MAX, 32'h0);
    add_request(CMD_UNUSED, 1, 32'hDEAD_BEEF);
    add_request(CMD_DELETE, 2, 32'hFFFF_FFFF);
    add_request(CMD_DELETE, 3, 32'h0);
    add_request(CMD_DELETE, 0, 32'h0);
    add_request(CMD_DELETE, POS_MAX, 32'h0);
    add_request(CMD_INSERT, POS_MAX, 32'hA5A5_5A5A);
    add_request(CMD_DELETE, 1, 32'h0);
    add_request(CMD_DELETE, 1, 32'h0);

    // random: alternate growing to full and draining to empty
    grow    = 1'b1;
    at_full = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (grow) begin
        cmd = (pick < 65) ? CMD_INSERT : (pick < 80) ? CMD_DELETE :
              (pick < 97) ? CMD_READ : CMD_UNUSED;
      end else begin
        cmd = (pick < 15) ? CMD_INSERT : (pick < 75) ? CMD_DELETE :
              (pick < 97) ? CMD_READ : CMD_UNUSED;
      end
      lim = (cmd == CMD_INSERT) ? plan_len + 1 : plan_len;
      sel = $urandom_range(0, 19);
      if (sel == 0) pos = 0;
      else if (sel == 1) pos = (lim + 1 > POS_MAX) ? POS_MAX : lim + 1;
      else if (sel == 2) pos = $urandom_range(0, POS_MAX);
      else if (sel == 3) pos = lim;
      else if (sel == 4) pos = 1;
      else pos = (lim == 0) ? 1 : $urandom_range(1, lim);
      sel = $urandom_range(0, 15);
      if (sel == 0) value = 32'h8000_0000;
      else if (sel == 1) value = 32'h7FFF_FFFF;
      else if (sel == 2) value = 32'hFFFF_FFFF;
      else if (sel == 3) value = 32'h0;
      else value = $urandom;
      add_request(cmd, pos, value);
      if (grow && plan_len == CAP) at_full++;
      if (grow && at_full >= 24) begin
        grow    = 1'b0;
        at_full = 0;
      end else if (!grow && plan_len == 0) begin
        grow = 1'b1;
      end
    end

    // reset
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain
    while (request_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0) @(negedge clk_i);
    repeat (2 * LATENCY + 4) @(negedge clk_i);

    $display("covered %0d requests: %0d ok, %0d out of range, %0d refused as full",
             req_count, n_ok, n_range, n_full);
    $display("deepest list held %0d entries; %0d mismatches", peak_len, err_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pal_pkg.sv
hdl/pal_cell.sv
hdl/pal_read_tree.sv
hdl/positional_array_list.sv
tb/positional_array_list_tb.sv
